/* hdl/fsw_pkg.sv */
// fsw_pkg: shared constants, command codes, sequencer states and the
// request/item structs of the flash sector write-back buffer
// no dependencies
package fsw_pkg;

  // geometry, all powers of two
  localparam int SECTORS_PER_BLOCK = 8;
  localparam int SECTOR_BYTES      = 512;
  localparam int ADDRESS_BITS      = 24;

  localparam int FIELD_W      = 24;
  localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);
  localparam int SECT_W       = $clog2(SECTORS_PER_BLOCK);
  localparam int BLOCK_SHIFT  = SECTOR_SHIFT + SECT_W;
  localparam int BLOCK_W      = ADDRESS_BITS - BLOCK_SHIFT;

  localparam logic [FIELD_W-1:0] SCRATCH_BASE_RESET = 24'h0FF000;

  typedef enum logic [2:0] {
    CMD_COPY_IN  = 3'd0,
    CMD_ERASE    = 3'd1,
    CMD_COPY_OUT = 3'd2,
    CMD_STAGE    = 3'd3,
    CMD_NONE     = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NONE,
    ST_COPY_IN,
    ST_ERASE_MAIN,
    ST_COPY_OUT,
    ST_ERASE_SCR,
    ST_STAGE
  } state_t;

  typedef enum logic [1:0] {
    BASE_ZERO,
    BASE_MAIN,
    BASE_SCRATCH
  } base_t;

  // command request from the sequencer to the address unit
  typedef struct packed {
    cmd_t                   cmd;
    base_t                  tgt_base;
    base_t                  src_base;
    logic [BLOCK_SHIFT-1:0] offset;
    logic [BLOCK_W-1:0]     block;
    logic                   last;
  } cmd_req_t;

  // finished command as presented on the output
  typedef struct packed {
    cmd_t               cmd;
    logic [FIELD_W-1:0] target;
    logic [FIELD_W-1:0] source;
    logic               last;
  } cmd_item_t;

endpackage

/* hdl/flash_sector_write_back_buffer.sv */
// flash_sector_write_back_buffer: top level, scratch base register,
// sequencer, shared address unit and output register
// depends on fsw_pkg, fsw_sequencer, fsw_addr_unit, fsw_out_reg
//
// Turns sector writes and flush requests into a stream of flash commands
// that buffer the writes of one open erase block in a scratch erase block.
// Each accepted item is followed by its commands, one per output item, the
// final one flagged by last. The block takes one item at a time: in_ready
// is high only while the sequencer is idle. A flush is paced by the sector
// counter, which walks every sector of the block once for the copy-in phase
// (dirty sectors give no command) and once for the copy-back phase; a
// stalled output holds the sequence. scratch_base may only be written while
// the block is idle; its low bits below the erase-block size are ignored.
module flash_sector_write_back_buffer
  import fsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // input items
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [23:0]        address,
  // result items
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         command,
  output logic [23:0]        target_address,
  output logic [23:0]        source_address,
  output logic               last,
  // configuration
  input  logic               cfg_wen,
  input  logic [23:0]        cfg_wdata
);

  logic [FIELD_W-1:0] scratch_base;
  logic               slot_free;
  logic               emit_valid;
  cmd_req_t           req;
  cmd_item_t          item_d;
  cmd_item_t          item_q;

  // scratch block location
  always_ff @(posedge clk) begin
    if (rst) begin
      scratch_base <= SCRATCH_BASE_RESET;
    end else if (cfg_wen) begin
      scratch_base <= cfg_wdata;
    end
  end

  // sequencer: open-block record and flush sweep
  fsw_sequencer u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .action     (action),
    .address    (address),
    .slot_free  (slot_free),
    .emit_valid (emit_valid),
    .req        (req)
  );

  // shared address generator
  fsw_addr_unit u_addr (
    .req          (req),
    .scratch_base (scratch_base),
    .item         (item_d)
  );

  // output register decouples the sequencer from the consumer
  fsw_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (emit_valid),
    .item_d    (item_d),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .item_q    (item_q),
    .slot_free (slot_free)
  );

  assign command        = item_q.cmd;
  assign target_address = item_q.target;
  assign source_address = item_q.source;
  assign last           = item_q.last;

  // an accepted item always takes the sequencer out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready held high after an item was accepted");

  // no command code beyond the defined set ever leaves
  a_cmd_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> command <= CMD_NONE)
    else $error("undefined command code on output");

  // only copies carry a source address
  a_src_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (command == CMD_ERASE || command == CMD_STAGE || command == CMD_NONE)
    |-> source_address == '0)
    else $error("source address set on a non-copy command");

  // erases always hit an erase-block boundary
  a_erase_aligned: assert property (@(posedge clk) disable iff (rst)
    out_valid && command == CMD_ERASE |-> target_address[BLOCK_SHIFT-1:0] == '0)
    else $error("erase target not block aligned");

endmodule

/* hdl/fsw_addr_unit.sv */
// fsw_addr_unit: shared address generator, base plus in-block offset
// for target and source of every command
// depends on fsw_pkg
module fsw_addr_unit
  import fsw_pkg::*;
(
  input  cmd_req_t           req,
  input  logic [FIELD_W-1:0] scratch_base,
  output cmd_item_t          item
);

  logic [ADDRESS_BITS-1:0] main_a;
  logic [ADDRESS_BITS-1:0] scr_a;
  logic [ADDRESS_BITS-1:0] off_a;
  logic [ADDRESS_BITS-1:0] tgt_b;
  logic [ADDRESS_BITS-1:0] src_b;
  logic [ADDRESS_BITS-1:0] tgt_sum;
  logic [ADDRESS_BITS-1:0] src_sum;

  always_comb begin
    main_a = {req.block, {BLOCK_SHIFT{1'b0}}};
    // scratch block aligned down
    scr_a  = ADDRESS_BITS'({scratch_base[FIELD_W-1:BLOCK_SHIFT], {BLOCK_SHIFT{1'b0}}});
    off_a  = ADDRESS_BITS'(req.offset);

    unique case (req.tgt_base)
      BASE_MAIN:    tgt_b = main_a;
      BASE_SCRATCH: tgt_b = scr_a;
      default:      tgt_b = '0;
    endcase
    unique case (req.src_base)
      BASE_MAIN:    src_b = main_a;
      BASE_SCRATCH: src_b = scr_a;
      default:      src_b = '0;
    endcase

    // sums wrap at the address width
    tgt_sum = (req.tgt_base == BASE_ZERO) ? '0 : tgt_b + off_a;
    src_sum = (req.src_base == BASE_ZERO) ? '0 : src_b + off_a;

    item.cmd    = req.cmd;
    item.target = FIELD_W'(tgt_sum);
    item.source = FIELD_W'(src_sum);
    item.last   = req.last;
  end

endmodule

/* hdl/fsw_out_reg.sv */
// fsw_out_reg: one-entry output register holding a finished command
// depends on fsw_pkg
module fsw_out_reg
  import fsw_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  cmd_item_t item_d,
  input  logic      out_ready,
  output logic      out_valid,
  output cmd_item_t item_q,
  output logic      slot_free
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && load) begin
      item_q <= item_d;
    end
  end

endmodule

/* hdl/fsw_sequencer.sv */
// fsw_sequencer: open-block record, dirty mask and the command sequencer
// that sweeps the sector counter through flushes
// depends on fsw_pkg
module fsw_sequencer
  import fsw_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic [FIELD_W-1:0] address,
  input  logic               slot_free,
  output logic               emit_valid,
  output cmd_req_t           req
);

  localparam logic [SECTORS_PER_BLOCK-1:0] ONE_BIT  = SECTORS_PER_BLOCK'(1);
  localparam logic [SECT_W-1:0]            LAST_SEC = SECT_W'(SECTORS_PER_BLOCK - 1);

  state_t                       state, state_next;
  logic [SECT_W-1:0]            sect_cnt;
  logic [BLOCK_W-1:0]           open_block;
  logic                         open_valid;
  logic [SECTORS_PER_BLOCK-1:0] dirty_mask;
  logic                         stage_pending;
  logic [BLOCK_W-1:0]           pend_block;
  logic [BLOCK_SHIFT-1:0]       pend_off;

  logic [ADDRESS_BITS-1:0]      in_addr;
  logic [BLOCK_W-1:0]           in_block;
  logic [SECTORS_PER_BLOCK-1:0] in_bit;
  logic                         need_flush;
  logic [SECTORS_PER_BLOCK-1:0] stage_mask;
  logic                         stage_full;
  logic                         accept;

  always_comb begin
    in_addr    = ADDRESS_BITS'(address);
    in_block   = in_addr[ADDRESS_BITS-1:BLOCK_SHIFT];
    in_bit     = ONE_BIT << in_addr[BLOCK_SHIFT-1:SECTOR_SHIFT];
    need_flush = open_valid && ((in_block != open_block) || ((dirty_mask & in_bit) != '0));
    stage_mask = dirty_mask | (ONE_BIT << pend_off[BLOCK_SHIFT-1:SECTOR_SHIFT]);
    stage_full = &stage_mask;
  end

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (action) state_next = open_valid ? ST_COPY_IN : ST_NONE;
          else        state_next = need_flush ? ST_COPY_IN : ST_STAGE;
        end
      end
      ST_NONE: begin
        if (slot_free) state_next = ST_IDLE;
      end
      ST_COPY_IN: begin
        if (slot_free && sect_cnt == LAST_SEC) state_next = ST_ERASE_MAIN;
      end
      ST_ERASE_MAIN: begin
        if (slot_free) state_next = ST_COPY_OUT;
      end
      ST_COPY_OUT: begin
        if (slot_free && sect_cnt == LAST_SEC) state_next = ST_ERASE_SCR;
      end
      ST_ERASE_SCR: begin
        if (slot_free) state_next = stage_pending ? ST_STAGE : ST_IDLE;
      end
      ST_STAGE: begin
        if (slot_free) state_next = stage_full ? ST_COPY_IN : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    emit_valid   = 1'b0;
    req.cmd      = CMD_NONE;
    req.tgt_base = BASE_ZERO;
    req.src_base = BASE_ZERO;
    req.offset   = '0;
    req.block    = open_block;
    req.last     = 1'b0;
    unique case (state)
      ST_IDLE: ;
      ST_NONE: begin
        emit_valid = 1'b1;
        req.last   = 1'b1;
      end
      ST_COPY_IN: begin
        emit_valid   = !dirty_mask[sect_cnt];
        req.cmd      = CMD_COPY_IN;
        req.tgt_base = BASE_SCRATCH;
        req.src_base = BASE_MAIN;
        req.offset   = {sect_cnt, {SECTOR_SHIFT{1'b0}}};
      end
      ST_ERASE_MAIN: begin
        emit_valid   = 1'b1;
        req.cmd      = CMD_ERASE;
        req.tgt_base = BASE_MAIN;
      end
      ST_COPY_OUT: begin
        emit_valid   = 1'b1;
        req.cmd      = CMD_COPY_OUT;
        req.tgt_base = BASE_MAIN;
        req.src_base = BASE_SCRATCH;
        req.offset   = {sect_cnt, {SECTOR_SHIFT{1'b0}}};
      end
      ST_ERASE_SCR: begin
        emit_valid   = 1'b1;
        req.cmd      = CMD_ERASE;
        req.tgt_base = BASE_SCRATCH;
        req.last     = !stage_pending;
      end
      ST_STAGE: begin
        emit_valid   = 1'b1;
        req.cmd      = CMD_STAGE;
        req.tgt_base = BASE_SCRATCH;
        req.offset   = pend_off;
        req.last     = !stage_full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      sect_cnt      <= '0;
      open_block    <= '0;
      open_valid    <= 1'b0;
      dirty_mask    <= '0;
      stage_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        stage_pending <= !action && need_flush;
        sect_cnt      <= '0;
      end
      if (slot_free) begin
        unique case (state)
          ST_COPY_IN, ST_COPY_OUT: begin
            sect_cnt <= (sect_cnt == LAST_SEC) ? '0 : sect_cnt + 1'b1;
          end
          ST_ERASE_SCR: begin
            open_valid    <= 1'b0;
            open_block    <= '0;
            dirty_mask    <= '0;
            stage_pending <= 1'b0;
          end
          ST_STAGE: begin
            open_block <= pend_block;
            open_valid <= 1'b1;
            dirty_mask <= stage_mask;
            sect_cnt   <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_block <= in_block;
      pend_off   <= in_addr[BLOCK_SHIFT-1:0];
    end
  end

endmodule
